// ===== sv/olist_pkg.sv =====
package olist_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned DEPTH_MAX     = 1024;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned STAT_W = 2;

  // Width of one slice of match flags that the search scan folds per cycle.
  localparam int unsigned GRP_W = 32;

  localparam int unsigned IDX_MAX_W = $clog2(DEPTH_MAX);
  localparam int unsigned CNT_MAX_W = $clog2(DEPTH_MAX + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_DEL_POS  = 3'd3,
    CMD_SEARCH   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_CMP  = 2'd3
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_e;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e               op;
    logic [IDX_MAX_W-1:0]   idx;
    logic [CNT_MAX_W-1:0]   cnt;
  } cell_ctl_t;

endpackage

// ===== sv/olist_cell.sv =====
module olist_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                                clk_i,
  input  olist_pkg::cell_ctl_t                ctl_i,
  input  logic signed [olist_pkg::VAL_W-1:0]  left_i,
  input  logic signed [olist_pkg::VAL_W-1:0]  right_i,
  input  logic signed [olist_pkg::VAL_W-1:0]  value_i,
  output logic signed [olist_pkg::VAL_W-1:0]  entry_o,
  output logic                                hit_o
);
  import olist_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MyIdx = IDX_MAX_W'(Index);
  localparam logic [CNT_MAX_W-1:0] MyCnt = CNT_MAX_W'(Index);

  logic signed [VAL_W-1:0] entry_q;
  logic                    hit_q;

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      CELL_INS: begin
        if (MyIdx > ctl_i.idx) begin
          entry_q <= left_i;
        end else if (MyIdx == ctl_i.idx) begin
          entry_q <= value_i;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= ctl_i.idx) begin
          entry_q <= right_i;
        end
      end
      CELL_CMP: begin
        hit_q <= (MyCnt < ctl_i.cnt) && (entry_q == value_i);
      end
      default: begin
      end
    endcase
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

// ===== sv/olist_chain.sv =====
module olist_chain #(
  parameter int unsigned Depth = olist_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  olist_pkg::cell_ctl_t                ctl_i,
  input  logic signed [olist_pkg::VAL_W-1:0]  value_i,
  output logic [Depth-1:0]                    hit_o
);
  import olist_pkg::*;

  logic signed [VAL_W-1:0] entry_w [Depth];

  // Cells see neighbors; cell 0's left is value_i and the last's right is itself.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w;
    logic signed [VAL_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_w = entry_w[i];
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
    end

    olist_cell #(
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .left_i  (left_w),
      .right_i (right_w),
      .value_i (value_i),
      .entry_o (entry_w[i]),
      .hit_o   (hit_o[i])
    );
  end

endmodule

// ===== sv/ordered_list_engine.sv =====
// Ordered list engine: a bounded list of signed 32-bit values held in a row
// of cells, one entry per cell, in list order.
// A request is taken at a rising clock edge where start is high and busy is
// low. It carries a command (insert at head, insert at tail, insert at a
// 1-based position, delete at a 1-based position, search), a position and a
// value. Every request produces exactly one result on found_o, length_o and
// status_o, marked by done_o for one cycle; the receiver cannot stall it.
// Inserts and deletes shift the affected cells at the accepting edge, so the
// result appears in the next cycle and busy never rises: one request per
// cycle is sustained. A search latches a match flag in every cell at the
// accepting edge, then folds the flags 32 at a time, one slice per cycle;
// it holds busy until the last slice is folded, then registers its result.
// The width of that slice OR sets the search latency.
// Reset empties the list at once; no clearing pass is needed, since only
// entries below the current length are ever examined.
module ordered_list_engine #(
  parameter int unsigned Depth = olist_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [olist_pkg::CMD_W-1:0]          cmd_i,
  input  logic [olist_pkg::POS_W-1:0]          position_i,
  input  logic signed [olist_pkg::VAL_W-1:0]   value_i,
  output logic                                 done_o,
  output logic                                 found_o,
  output logic [olist_pkg::LEN_W-1:0]          length_o,
  output logic [olist_pkg::STAT_W-1:0]         status_o
);
  import olist_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;
  localparam int unsigned NGrp = (Depth + GRP_W - 1) / GRP_W;
  localparam int unsigned GrpW = (NGrp > 1) ? $clog2(NGrp) : 1;

  fsm_e               state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [GrpW-1:0]    grp_q, grp_d;
  logic               acc_q, acc_d;
  logic               done_q, done_d;
  logic               found_q, found_d;
  status_e            status_q, status_d;
  status_e            stat;
  cell_ctl_t          ctl;

  logic [Depth-1:0]        hit_w;
  logic [NGrp*GRP_W-1:0]   hit_pad;
  logic                    grp_hit;
  logic [CmpW-1:0]         pos_ext;
  logic [CmpW-1:0]         pos_m1;
  logic [CmpW-1:0]         cnt_ext;
  logic                    full;
  logic                    empty;
  logic                    pos_zero;

  olist_chain #(
    .Depth (Depth)
  ) u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .value_i (value_i),
    .hit_o   (hit_w)
  );

  // Pad the match flags to whole slices; padding cells never match.
  assign hit_pad  = (NGrp*GRP_W)'(hit_w);
  assign grp_hit  = |hit_pad[grp_q*GRP_W +: GRP_W];

  assign pos_ext  = CmpW'(position_i);
  assign pos_m1   = pos_ext - CmpW'(1);
  assign cnt_ext  = CmpW'(count_q);
  assign pos_zero = (position_i == '0);
  assign full     = (count_q == CntW'(Depth));
  assign empty    = (count_q == '0);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    grp_d    = grp_q;
    acc_d    = acc_q;
    done_d   = 1'b0;
    found_d  = found_q;
    status_d = status_q;
    stat     = ST_OK;
    ctl.op   = CELL_HOLD;
    ctl.idx  = '0;
    ctl.cnt  = CNT_MAX_W'(count_q);

    case (state_q)
      FSM_IDLE: begin
        if (start) begin
          done_d  = 1'b1;
          found_d = 1'b0;
          case (cmd_e'(cmd_i))
            CMD_INS_HEAD: begin
              if (full) begin
                stat = ST_FULL;
              end else begin
                ctl.op  = CELL_INS;
                count_d = count_q + CntW'(1);
              end
            end
            CMD_INS_TAIL: begin
              if (full) begin
                stat = ST_FULL;
              end else begin
                ctl.op  = CELL_INS;
                ctl.idx = IDX_MAX_W'(count_q);
                count_d = count_q + CntW'(1);
              end
            end
            CMD_INS_POS: begin
              if (full) begin
                stat = ST_FULL;
              end else if (pos_zero || (pos_m1 > cnt_ext)) begin
                stat = ST_BAD_POS;
              end else begin
                ctl.op  = CELL_INS;
                ctl.idx = IDX_MAX_W'(pos_m1);
                count_d = count_q + CntW'(1);
              end
            end
            CMD_DEL_POS: begin
              if (empty) begin
                stat = ST_EMPTY;
              end else if (pos_zero || (pos_ext > cnt_ext)) begin
                stat = ST_BAD_POS;
              end else begin
                ctl.op  = CELL_DEL;
                ctl.idx = IDX_MAX_W'(pos_m1);
                count_d = count_q - CntW'(1);
              end
            end
            CMD_SEARCH: begin
              ctl.op  = CELL_CMP;
              done_d  = 1'b0;
              grp_d   = '0;
              acc_d   = 1'b0;
              state_d = FSM_SCAN;
            end
            default: begin
            end
          endcase
          status_d = stat;
        end
      end
      FSM_SCAN: begin
        acc_d = acc_q | grp_hit;
        if (grp_q == GrpW'(NGrp - 1)) begin
          done_d  = 1'b1;
          found_d = acc_q | grp_hit;
          state_d = FSM_IDLE;
        end else begin
          grp_d = grp_q + GrpW'(1);
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      count_q <= '0;
      grp_q   <= '0;
      acc_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      grp_q   <= grp_d;
      acc_q   <= acc_d;
      done_q  <= done_d;
    end
  end

  // Result fields are only meaningful while done_o is high.
  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign busy     = (state_q != FSM_IDLE);
  assign done_o   = done_q;
  assign found_o  = found_q;
  assign status_o = status_q;
  assign length_o = LEN_W'(count_q);

  // An accepted update request answers in the very next cycle.
  a_update_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i != CMD_SEARCH)) |=> done_o)
    else $error("update request did not answer in one cycle");

  // A result is never shown while a search is still being folded.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // The list never holds more entries than there are cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("list length exceeds depth");

  // A full status means the list really is full.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> full)
    else $error("full status with room left");

  // Found is only raised by a search, which always passes through the scan.
  a_found_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> ($past(state_q) == FSM_SCAN))
    else $error("found raised outside a search");

endmodule
